// ===== src/tlbc_pkg.sv =====
`timescale 1ns / 1ps
// tlbc_pkg: constants, sequencer codes and saturation helper for the
// three-leg bridge converter step core; no dependencies

package tlbc_pkg;

  // datapath width as configured; anything above 32 behaves as 32
  localparam int DATA_WIDTH = 32;
  localparam int VAL_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int VAL_W      = 32;    // port width of every value field
  localparam int ACC_W      = 34;    // width of short sums of three values

  localparam logic signed [63:0] VAL_MAX = 64'sd2 ** (VAL_BITS - 1) - 64'sd1;
  localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

  localparam int NUM_LEGS = 3;
  localparam int IN_W     = 200;     // 196 payload bits padded to whole bytes
  localparam int OUT_W    = 224;

  // configuration register indexes
  localparam logic [1:0] REG_CAP_G   = 2'd0;
  localparam logic [1:0] REG_STEP_C  = 2'd1;
  localparam logic [1:0] REG_STEP_L  = 2'd2;
  localparam logic [1:0] REG_SER_RES = 2'd3;

  localparam logic [31:0] CAP_G_RESET   = 32'h0001_0000;
  localparam logic [31:0] SER_RES_RESET = 32'h0001_0000;

  // sequencer slots at which each multiply is issued
  localparam logic [3:0] ISS_IPOS   = 4'd0;
  localparam logic [3:0] ISS_INEG   = 4'd1;
  localparam logic [3:0] ISS_DROP_A = 4'd2;  // legs a, b, c follow
  localparam logic [3:0] ISS_DV_A   = 4'd5;  // legs a, b, c follow
  localparam logic [3:0] ISS_HI     = 4'd8;
  localparam logic [3:0] ISS_LO     = 4'd9;
  localparam logic [3:0] ISS_SRC_P  = 4'd11;
  localparam logic [3:0] ISS_SRC_N  = 4'd12;
  localparam logic [3:0] PIPE_LAG   = 4'd2;  // operand reg, product reg
  localparam logic [3:0] SLOT_LAST  = 4'd14;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic signed [31:0] sat_val(input logic signed [63:0] x);
    logic signed [63:0] r;
    begin
      if (x > VAL_MAX) begin
        r = VAL_MAX;
      end else if (x < VAL_MIN) begin
        r = VAL_MIN;
      end else begin
        r = x;
      end
      return r[31:0];
    end
  endfunction

  function automatic logic signed [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

// ===== src/three_leg_bridge_converter_step_core.sv =====
`timescale 1ns / 1ps
// three_leg_bridge_converter_step_core: one simulation time step of a
// three-phase two-level bridge companion model; depends on tlbc_pkg
//
//   channel   direction  signals                          transaction
//   s_*       in         s_tvalid s_tready s_tdata[199:0] one time step
//   m_*       out        m_tvalid m_tready m_tdata[223:0] step results
//   cfg_*     in         cfg_we cfg_index[1:0] cfg_data   register write
//
// an accepted step runs through 15 sequencer slots after the accept cycle,
// driving one shared 32x32 signed-by-unsigned multiplier with a two-deep
// pipeline (operand register, product register); twelve products are formed per step;
// s_tready is high only while the sequencer is idle; the result register
// parts the sides, so a new step is taken while a result waits, and the
// sequencer holds in its last slot only if the previous result is still
// unclaimed; rst (synchronous) restores register defaults and zero state

module three_leg_bridge_converter_step_core (
  input  logic                        clk,
  input  logic                        rst,
  // pos_rail_volt, mid_volt, neg_rail_volt, out_a_volt, out_b_volt,
  // out_c_volt (32 each), leg_ctrl (3), gate_enable (1), zero pad (4)
  input  logic [tlbc_pkg::IN_W-1:0]   s_tdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // src_pos, src_neg, cap_hi_volt, cap_lo_volt, leg_a_amp, leg_b_amp,
  // leg_c_amp (32 each)
  output logic [tlbc_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int VW = tlbc_pkg::VAL_W;
  localparam int AW = tlbc_pkg::ACC_W;
  localparam int NL = tlbc_pkg::NUM_LEGS;

  // configuration registers
  logic [31:0] cap_g, step_c, step_l, ser_res;

  // converter state
  logic signed [VW-1:0] cap_hi, cap_lo;
  logic signed [VW-1:0] il [NL];

  // per-step working registers
  tlbc_pkg::state_t     state;
  logic [3:0]           slot;
  logic signed [VW-1:0] vp, vg, vn;
  logic signed [AW-1:0] pre [NL];     // leg voltage + ground - output
  logic signed [VW-1:0] dv [NL];
  logic                 on_up [NL];
  logic                 on_lo [NL];
  logic signed [AW-1:0] up_sum, lo_sum;
  logic signed [VW-1:0] ipos, ineg, src_pos;

  // shared multiplier
  logic signed [VW-1:0] mul_a;
  logic [31:0]          mul_b;
  logic signed [63:0]   prod;
  logic signed [63:0]   prod_full;

  logic                 accept, out_free, run_go;
  logic [3:0]           cslot;
  logic signed [63:0]   p16, p32;

  // input decode, saturated to the datapath range
  logic signed [VW-1:0] in_v [6];
  logic [2:0]           in_ctrl;
  logic                 in_en;
  logic signed [VW-1:0] leg_v [NL];
  logic                 up_next [NL];
  logic                 lo_next [NL];

  assign in_ctrl  = s_tdata[194:192];
  assign in_en    = s_tdata[195];
  assign s_tready = (state == tlbc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign run_go   = (state == tlbc_pkg::ST_RUN) &&
                    ((slot != tlbc_pkg::SLOT_LAST) || out_free);
  assign cslot    = slot - tlbc_pkg::PIPE_LAG;

  // exact: a signed 32-bit times an unsigned 32-bit value fits in 64 bits
  assign prod_full = mul_a * $signed({1'b0, mul_b});
  // floor shifts of the registered product
  assign p16 = prod >>> 16;
  assign p32 = prod >>> 32;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_v[i] = tlbc_pkg::sat_val(tlbc_pkg::sx32(s_tdata[i*VW +: VW]));
    end
    // rail selection per leg: gates, else diodes by current sign,
    // else clamp of the output voltage between the capacitors
    for (int k = 0; k < NL; k++) begin
      up_next[k] = 1'b0;
      lo_next[k] = 1'b0;
      if (in_en) begin
        if (in_ctrl[k]) begin
          leg_v[k]   = cap_hi;
          up_next[k] = 1'b1;
        end else begin
          leg_v[k]   = cap_lo;
          lo_next[k] = 1'b1;
        end
      end else if (il[k] > 0) begin
        leg_v[k]   = cap_lo;
        lo_next[k] = 1'b1;
      end else if (il[k] < 0) begin
        leg_v[k]   = cap_hi;
        up_next[k] = 1'b1;
      end else if (in_v[3+k] > cap_hi) begin
        leg_v[k] = cap_hi;
      end else if (in_v[3+k] < cap_lo) begin
        leg_v[k] = cap_lo;
      end else begin
        leg_v[k] = in_v[3+k];
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_g   <= tlbc_pkg::CAP_G_RESET;
      step_c  <= '0;
      step_l  <= '0;
      ser_res <= tlbc_pkg::SER_RES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tlbc_pkg::REG_CAP_G:   cap_g   <= cfg_data;
        tlbc_pkg::REG_STEP_C:  step_c  <= cfg_data;
        tlbc_pkg::REG_STEP_L:  step_l  <= cfg_data;
        tlbc_pkg::REG_SER_RES: ser_res <= cfg_data;
        default: ;
      endcase
    end
  end

  // product register runs every cycle
  always_ff @(posedge clk) begin
    prod <= prod_full;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlbc_pkg::ST_IDLE;
      slot     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= tlbc_pkg::ST_RUN;
        slot  <= '0;
      end else if (run_go) begin
        if (slot == tlbc_pkg::SLOT_LAST) begin
          state <= tlbc_pkg::ST_IDLE;
        end else begin
          slot <= slot + 4'd1;
        end
      end
      // a finishing step presents its result, else a taken result clears
      if (run_go && (slot == tlbc_pkg::SLOT_LAST)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // converter state: cleared by reset, written back from the product
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_hi <= '0;
      cap_lo <= '0;
      for (int k = 0; k < NL; k++) begin
        il[k] <= '0;
      end
    end else if (run_go) begin
      for (int k = 0; k < NL; k++) begin
        if (cslot == tlbc_pkg::ISS_DV_A + 4'(k)) begin
          il[k] <= tlbc_pkg::sat_val(tlbc_pkg::sx32(il[k]) + p32);
        end
      end
      if (cslot == tlbc_pkg::ISS_HI) begin
        cap_hi <= tlbc_pkg::sat_val(tlbc_pkg::sx32(cap_hi) + p32);
      end
      if (cslot == tlbc_pkg::ISS_LO) begin
        cap_lo <= tlbc_pkg::sat_val(tlbc_pkg::sx32(cap_lo) + p32);
      end
    end
  end

  // working registers: capture, operand issue, result consumption
  always_ff @(posedge clk) begin
    if (accept) begin
      vp     <= in_v[0];
      vg     <= in_v[1];
      vn     <= in_v[2];
      up_sum <= '0;
      lo_sum <= '0;
      for (int k = 0; k < NL; k++) begin
        on_up[k] <= up_next[k];
        on_lo[k] <= lo_next[k];
        pre[k]   <= AW'(tlbc_pkg::sx32(leg_v[k]) + tlbc_pkg::sx32(in_v[1])
                      - tlbc_pkg::sx32(in_v[3+k]));
      end
    end else if (run_go) begin
      // operand issue
      case (slot)
        tlbc_pkg::ISS_IPOS: begin
          mul_a <= tlbc_pkg::sat_val(tlbc_pkg::sx32(vp) - tlbc_pkg::sx32(cap_hi)
                                     - tlbc_pkg::sx32(vg));
          mul_b <= cap_g;
        end
        tlbc_pkg::ISS_INEG: begin
          mul_a <= tlbc_pkg::sat_val(tlbc_pkg::sx32(vn) - tlbc_pkg::sx32(cap_lo)
                                     - tlbc_pkg::sx32(vg));
          mul_b <= cap_g;
        end
        tlbc_pkg::ISS_HI: begin
          mul_a <= tlbc_pkg::sat_val(tlbc_pkg::sx32(ipos) - 64'(up_sum));
          mul_b <= step_c;
        end
        tlbc_pkg::ISS_LO: begin
          mul_a <= tlbc_pkg::sat_val(tlbc_pkg::sx32(ineg) - 64'(lo_sum));
          mul_b <= step_c;
        end
        tlbc_pkg::ISS_SRC_P: begin
          mul_a <= cap_hi;
          mul_b <= cap_g;
        end
        tlbc_pkg::ISS_SRC_N: begin
          mul_a <= cap_lo;
          mul_b <= cap_g;
        end
        default: ;
      endcase
      for (int k = 0; k < NL; k++) begin
        // series drop, and the capacitor current sums from the old currents
        if (slot == tlbc_pkg::ISS_DROP_A + 4'(k)) begin
          mul_a <= il[k];
          mul_b <= ser_res;
          if (on_up[k]) begin
            up_sum <= up_sum + AW'(il[k]);
          end
          if (on_lo[k]) begin
            lo_sum <= lo_sum + AW'(il[k]);
          end
        end
        if (slot == tlbc_pkg::ISS_DV_A + 4'(k)) begin
          mul_a <= dv[k];
          mul_b <= step_l;
        end
      end

      // result consumption, once the product has passed the operand and product registers
      case (cslot)
        tlbc_pkg::ISS_IPOS:  ipos    <= tlbc_pkg::sat_val(p16);
        tlbc_pkg::ISS_INEG:  ineg    <= tlbc_pkg::sat_val(p16);
        tlbc_pkg::ISS_SRC_P: src_pos <= tlbc_pkg::sat_val(p16);
        tlbc_pkg::ISS_SRC_N: begin
          m_tdata <= {il[2], il[1], il[0], cap_lo, cap_hi,
                      tlbc_pkg::sat_val(p16), src_pos};
        end
        default: ;
      endcase
      for (int k = 0; k < NL; k++) begin
        // drop kept at full width inside the voltage sum
        if (cslot == tlbc_pkg::ISS_DROP_A + 4'(k)) begin
          dv[k] <= tlbc_pkg::sat_val(64'(pre[k]) - p16);
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted step always starts the sequencer from its first slot
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == tlbc_pkg::ST_RUN) && (slot == '0))
    else $error("sequencer did not start on accept");

  // the slot counter never runs past the last slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == tlbc_pkg::ST_RUN) |-> (slot <= tlbc_pkg::SLOT_LAST))
    else $error("slot counter out of range");

  // finishing a step always presents a result and frees the input
  a_finish: assert property (@(posedge clk) disable iff (rst)
    ((state == tlbc_pkg::ST_RUN) && (slot == tlbc_pkg::SLOT_LAST) && out_free)
    |=> m_tvalid && s_tready)
    else $error("finished step did not produce a result");

  // the last slot never overwrites an unclaimed result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost");
`endif

endmodule
